// ===== src/lru_key_value_cache_unit_macros.svh =====
// ------------------------------------------------------------------------
// lru key/value cache assertion macros
// shared concurrent assertion forms, clocked on clk
// ------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// checked outside reset only
`define LKVC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LKVC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lkvc_pkg.sv =====
// ------------------------------------------------------------------------
// lkvc_pkg
// sizes, types and codes shared by the lru key/value cache modules
// ------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int CAP_BITS    = 5;
	localparam int CAP_RESET   = 16;

	localparam int IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_BITS  = IDX_BITS;
	localparam int COUNT_BITS = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

	typedef enum logic {
		FUNC_GET = 1'b0,
		FUNC_PUT = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load_item;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== src/lkvc_ctrl.sv =====
// ------------------------------------------------------------------------
// lkvc_ctrl
// sequencer: take a word, look it up, commit the update and the result
// ------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_unit_macros.svh"

module lkvc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output lkvc_pkg::ctrl_cmd_t     cmd
);

	lkvc_pkg::state_t state_q, state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = lkvc_pkg::ST_LOOKUP;
			end
			lkvc_pkg::ST_LOOKUP: begin
				state_nxt = lkvc_pkg::ST_UPDATE;
			end
			lkvc_pkg::ST_UPDATE: begin
				if (out_free) state_nxt = lkvc_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.lookup    = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			lkvc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			lkvc_pkg::ST_UPDATE: begin
				// state and result land together once the output slot is free
				cmd.commit = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkvc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`LKVC_ASSERT(a_commit_shows_result, cmd.commit |=> out_valid_q, "commit without result")
	`LKVC_ASSERT(a_stalled_result_holds, out_valid_q && !out_ready |=> out_valid_q,
		"result dropped while stalled")
	`LKVC_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.load_item, cmd.lookup, cmd.commit}),
		"more than one command at once")

endmodule

`default_nettype wire

// ===== src/lkvc_datapath.sv =====
// ------------------------------------------------------------------------
// lkvc_datapath
// entry store, parallel key match, recency ranks and result register
// ------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_unit_macros.svh"

module lkvc_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire lkvc_pkg::ctrl_cmd_t                   cmd,
	input  wire logic                                  cfg_we,
	input  wire logic [lkvc_pkg::CAP_BITS-1:0]         cfg_data,
	input  wire logic                                  func,
	input  wire logic signed [lkvc_pkg::KEY_BITS-1:0]  lookup_key,
	input  wire logic signed [lkvc_pkg::VALUE_BITS-1:0] write_value,
	output logic                                       hit,
	output logic signed [lkvc_pkg::VALUE_BITS-1:0]     read_value,
	output logic                                       evicted,
	output logic signed [lkvc_pkg::KEY_BITS-1:0]       evicted_key
);

	localparam int N = lkvc_pkg::MAX_ENTRIES;

	// latched item
	logic                            func_q;
	logic [lkvc_pkg::KEY_BITS-1:0]   key_q;
	logic [lkvc_pkg::VALUE_BITS-1:0] val_q;

	// entry state
	logic [lkvc_pkg::KEY_BITS-1:0]   key_store_q   [N];
	logic [lkvc_pkg::VALUE_BITS-1:0] value_store_q [N];
	logic [N-1:0]                    valid_q;
	logic [lkvc_pkg::RANK_BITS-1:0]  rank_q        [N];
	logic [lkvc_pkg::COUNT_BITS-1:0] fill_q;
	logic [lkvc_pkg::CAP_BITS-1:0]   cap_q;

	// lookup results
	logic                          hit_q, evict_q;
	logic [lkvc_pkg::IDX_BITS-1:0] match_idx_q, victim_idx_q, free_idx_q;

	logic [N-1:0]                  match_vec;
	logic                          match_any, evict_need;
	logic [lkvc_pkg::IDX_BITS-1:0] match_idx, victim_idx, free_idx;
	logic [lkvc_pkg::RANK_BITS-1:0] oldest_rank;
	logic [lkvc_pkg::CMP_BITS-1:0] fill_w, cap_w;

	assign fill_w      = lkvc_pkg::CMP_BITS'(fill_q);
	assign cap_w       = lkvc_pkg::CMP_BITS'(cap_q);
	assign oldest_rank = lkvc_pkg::RANK_BITS'(fill_q - lkvc_pkg::COUNT_BITS'(1));

	// capacity zero behaves as one, above the store size as the store size
	assign evict_need = (fill_q >= lkvc_pkg::COUNT_BITS'(N))
		|| ((fill_q != '0) && (fill_w >= cap_w));

	always_comb begin
		match_idx  = '0;
		victim_idx = '0;
		free_idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			match_vec[i] = valid_q[i] && (key_store_q[i] == key_q);
			if (match_vec[i]) match_idx = lkvc_pkg::IDX_BITS'(i);
			if (valid_q[i] && (rank_q[i] == oldest_rank)) victim_idx = lkvc_pkg::IDX_BITS'(i);
			if (!valid_q[i]) free_idx = lkvc_pkg::IDX_BITS'(i);
		end
		match_any = |match_vec;
	end

	// commit-side decode
	logic                           is_put, put_new;
	logic [lkvc_pkg::IDX_BITS-1:0]  slot;
	logic [lkvc_pkg::RANK_BITS-1:0] touch_age;

	assign is_put    = (func_q == lkvc_pkg::FUNC_PUT);
	assign put_new   = is_put && !hit_q;
	assign slot      = evict_q ? victim_idx_q : free_idx_q;
	assign touch_age = rank_q[match_idx_q];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			key_q  <= lookup_key;
			val_q  <= write_value;
		end
		if (cmd.lookup) begin
			hit_q        <= match_any;
			match_idx_q  <= match_idx;
			victim_idx_q <= victim_idx;
			free_idx_q   <= free_idx;
			evict_q      <= evict_need;
		end
		if (cmd.commit) begin
			hit <= hit_q;
			if (is_put) read_value <= '0;
			else if (hit_q) read_value <= value_store_q[match_idx_q];
			else read_value <= '1;
			evicted     <= put_new && evict_q;
			evicted_key <= (put_new && evict_q) ? key_store_q[victim_idx_q] : '0;
			if (is_put && hit_q) value_store_q[match_idx_q] <= val_q;
			if (put_new) begin
				key_store_q[slot]   <= key_q;
				value_store_q[slot] <= val_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			cap_q   <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
			for (int i = 0; i < N; i++) rank_q[i] <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.commit) begin
				if (hit_q) begin
					// move to front, younger entries age by one
					for (int i = 0; i < N; i++) begin
						if (valid_q[i] && (rank_q[i] < touch_age)) rank_q[i] <= rank_q[i] + 1'b1;
					end
					rank_q[match_idx_q] <= '0;
				end else if (is_put) begin
					for (int i = 0; i < N; i++) begin
						if (valid_q[i] && (lkvc_pkg::IDX_BITS'(i) != slot))
							rank_q[i] <= rank_q[i] + 1'b1;
					end
					rank_q[slot]  <= '0;
					valid_q[slot] <= 1'b1;
					if (!evict_q) fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	`LKVC_ASSERT_ALWAYS(a_fill_matches_valid, $countones(valid_q) == int'(fill_q),
		"fill count out of step with valid entries")
	`LKVC_ASSERT(a_insert_grows, cmd.commit && put_new && !evict_q
		|=> fill_q == $past(fill_q) + 1'b1, "insert did not grow the fill count")
	`LKVC_ASSERT(a_evict_only_full, cmd.commit && put_new && evict_q |-> fill_q != '0,
		"eviction from an empty store")

endmodule

`default_nettype wire

// ===== src/lru_key_value_cache_unit.sv =====
// ------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key/value cache with least-recently-used replacement.
// input channel (in_valid/in_ready) carries one word: func (get or put),
// lookup_key and write_value. output channel (out_valid/out_ready) returns
// one word per input: hit, read_value, evicted and evicted_key.
// configuration channel (cfg_valid/cfg_ready) writes capacity_limit; it is
// always ready. the user must write it only while the cache is idle; the
// block itself does not enforce this. each word is latched at acceptance,
// keys are matched and the victim found in the next cycle, and the
// entries update and the result register loads in the update step after
// it; a new word is accepted only after the previous word has committed.
// the result register frees the input side: the next word is taken while
// a result waits. if the receiver stalls, the update step holds until the
// result register frees, and no further word is accepted meanwhile.
// reset empties the cache and sets capacity_limit to 16.
// ------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lkvc_pkg::CAP_BITS-1:0]         cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  func,
	input  wire logic signed [lkvc_pkg::KEY_BITS-1:0]  lookup_key,
	input  wire logic signed [lkvc_pkg::VALUE_BITS-1:0] write_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       hit,
	output logic signed [lkvc_pkg::VALUE_BITS-1:0]     read_value,
	output logic                                       evicted,
	output logic signed [lkvc_pkg::KEY_BITS-1:0]       evicted_key
);

	lkvc_pkg::ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lkvc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.func        (func),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

`default_nettype wire
